// ===== rtl/core/hcs_pkg.sv =====
// Package for the hack_cpu_step unit: item structs, field widths and opcode bit positions.
// Used by every module under rtl/core. Depends on nothing.
package hcs_pkg;

    localparam int WORD_BITS = 16;
    localparam int ADDR_BITS = 15;
    localparam int PC_BITS   = 15;

    localparam int TYPE_BIT  = 15;
    localparam int ABIT      = 12;
    localparam int CTL_HI    = 11;
    localparam int CTL_LO    = 6;
    localparam int DEST_A    = 5;
    localparam int DEST_D    = 4;
    localparam int DEST_M    = 3;
    localparam int JMP_LT    = 2;
    localparam int JMP_EQ    = 1;
    localparam int JMP_GT    = 0;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [PC_BITS-1:0]   pc_t;

    typedef struct packed {
        logic zx;
        logic nx;
        logic zy;
        logic ny;
        logic f;
        logic no;
    } alu_ctl_t;

    typedef struct packed {
        word_t instruction;
        word_t mem_data;
    } in_t;

    typedef struct packed {
        logic  mem_write;
        addr_t write_address;
        word_t write_value;
        addr_t read_address;
        addr_t next_pc;
    } out_t;

endpackage

// ===== rtl/core/hcs_alu.sv =====
// Hack ALU: zero/negate both operands, add or AND, optional output negate.
// Depends on hcs_pkg.
module hcs_alu (
    input  hcs_pkg::word_t    x,
    input  hcs_pkg::word_t    y,
    input  hcs_pkg::alu_ctl_t ctl,
    output hcs_pkg::word_t    res
);
    import hcs_pkg::*;

    word_t xz;
    word_t xn;
    word_t yz;
    word_t yn;
    word_t fr;

    always_comb
    begin
        xz  = ctl.zx ? '0 : x;
        xn  = ctl.nx ? ~xz : xz;
        yz  = ctl.zy ? '0 : y;
        yn  = ctl.ny ? ~yz : yz;
        fr  = ctl.f ? word_t'(xn + yn) : (xn & yn);
        res = ctl.no ? ~fr : fr;
    end

endmodule

// ===== rtl/core/hcs_exec.sv =====
// Instruction execute: A, D and PC registers, decode, jump test and result build.
// Depends on hcs_pkg and hcs_alu.
module hcs_exec (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          commit,
    input  hcs_pkg::in_t  item,
    output hcs_pkg::out_t result
);
    import hcs_pkg::*;

    word_t a_reg;
    word_t a_next;
    word_t d_reg;
    word_t d_next;
    pc_t   pc_reg;
    pc_t   pc_next;

    word_t    y_sel;
    word_t    alu_res;
    alu_ctl_t ctl;
    logic     is_c;
    logic     neg;
    logic     zero;
    logic     take;

    assign is_c  = item.instruction[TYPE_BIT];
    assign ctl   = alu_ctl_t'(item.instruction[CTL_HI:CTL_LO]);
    assign y_sel = item.instruction[ABIT] ? item.mem_data : a_reg;

    hcs_alu u_alu (
        .x   (d_reg),
        .y   (y_sel),
        .ctl (ctl),
        .res (alu_res)
    );

    always_comb
    begin
        neg  = alu_res[WORD_BITS-1];
        zero = (alu_res == '0);
        take = is_c && ((item.instruction[JMP_LT] && neg)
                     || (item.instruction[JMP_EQ] && zero)
                     || (item.instruction[JMP_GT] && !neg && !zero));

        a_next = a_reg;
        d_next = d_reg;
        if (is_c)
        begin
            if (item.instruction[DEST_A])
            begin
                a_next = alu_res;
            end
            if (item.instruction[DEST_D])
            begin
                d_next = alu_res;
            end
        end
        else
        begin
            a_next = {1'b0, item.instruction[ADDR_BITS-1:0]};
        end
        pc_next = take ? a_reg[PC_BITS-1:0] : pc_t'(pc_reg + 1'b1);

        result.mem_write     = is_c && item.instruction[DEST_M];
        result.write_address = result.mem_write ? a_reg[ADDR_BITS-1:0] : '0;
        result.write_value   = result.mem_write ? alu_res : '0;
        result.read_address  = a_next[ADDR_BITS-1:0];
        result.next_pc       = addr_t'(pc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= '0;
            d_reg  <= '0;
            pc_reg <= '0;
        end
        else if (commit)
        begin
            a_reg  <= a_next;
            d_reg  <= d_next;
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/core/hack_cpu_step_unit.sv =====
// Hack CPU step unit: input item register, execute logic, result register.
// Items pass the input register, then the result register; one item per cycle unless result_ready stalls.
// Each register holds one item; while a result waits, input is taken only into an empty input register.
// The A/D/PC state updates as an item moves into the result register.
// Reset (rst_n low, async): A, D and PC clear to zero and both registers empty.
// Depends on hcs_pkg and hcs_exec.
module hack_cpu_step_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          instr_valid,
    output logic          instr_ready,
    input  hcs_pkg::in_t  instr,
    output logic          result_valid,
    input  logic          result_ready,
    output hcs_pkg::out_t result
);
    import hcs_pkg::*;

    logic in_valid_reg;
    in_t  in_data_reg;
    logic out_valid_reg;
    out_t out_data_reg;
    out_t exec_out;
    logic advance;

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign instr_ready  = !in_valid_reg || !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    hcs_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (in_data_reg),
        .result (exec_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (instr_ready)
            begin
                in_valid_reg <= instr_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr_valid && instr_ready)
        begin
            in_data_reg <= instr;
        end
        if (advance)
        begin
            out_data_reg <= exec_out;
        end
    end

endmodule

// ===== rtl/core/hcs_checker.sv =====
// Port-level checks for hack_cpu_step_unit, attached by the bind below.
// Depends on hcs_pkg and hack_cpu_step_unit.
module hcs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          instr_valid,
    input logic          instr_ready,
    input logic          result_valid,
    input logic          result_ready,
    input hcs_pkg::out_t result
);
    import hcs_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result item changed while stalled");

    a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.mem_write |->
            result.write_address == '0 && result.write_value == '0)
        else $error("store fields nonzero without mem_write");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> instr_ready)
        else $error("input stalled with empty result register");

    a_accept_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        instr_valid && instr_ready && !result_valid |=> ##1 result_valid)
        else $error("accepted item produced no result");

endmodule

bind hack_cpu_step_unit hcs_checker u_hcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
